// ===== design/ipcs_pkg.sv =====
package ipcs_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_PROD_W       = 14 + SIN_IDX_W;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  localparam logic [15:0] PERIOD_RESET = 16'd4000;

  // 2 * sqrt(3)/2 in Q16
  localparam logic signed [18:0] SQRT3_X2 = 19'sd113512;

  localparam int PROD_W = 33;          // Q1.15 x sine word
  localparam int AB_W   = 34;          // alpha/beta, Q30
  localparam int R_W    = 52;          // references, Q47
  localparam int T_W    = R_W - 16;    // active vector times, Q32, non-negative
  localparam int M_W    = 16 + T_W;    // period x time
  localparam int D_W    = M_W + 3;     // doubled duties, signed

  typedef enum logic [2:0] {
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5,
    SEC_6 = 3'd6
  } sector_t;

  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
    logic signed [15:0] vd;
    logic signed [15:0] vq;
  } sc_t;

  typedef struct packed {
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
  } ab_t;

  typedef struct packed {
    sector_t        sector;
    logic [T_W-1:0] t1;
    logic [T_W-1:0] t2;
  } sect_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    sector_t     sector;
  } res_t;

  // Quarter-wave sine entry, Q15, from a Taylor series in Q30 (elaboration only)
  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        q;
    x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n];
      if (n[0]) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      return 16'd0;
    end
    q = (unsigned'(acc) + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[15:0];
  endfunction

  function automatic logic [SIN_IDX_W-1:0] sine_addr(input logic [15:0] a);
    logic [SIN_PROD_W-1:0] prod;
    logic [SIN_IDX_W-1:0]  idx;
    prod = SIN_PROD_W'(a[13:0]) * SIN_PROD_W'(SINE_TABLE_DEPTH);
    idx  = prod[SIN_PROD_W-1:14];
    return a[14] ? SIN_IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
  endfunction

endpackage

// ===== design/ipcs_if.sv =====
interface ipcs_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        angle;
  logic signed [15:0] vd;
  logic signed [15:0] vq;

  modport source (output valid, angle, vd, vq, input ready);
  modport sink (input valid, angle, vd, vq, output ready);
endinterface

interface ipcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic [2:0]  sector;

  modport source (output valid, duty_a, duty_b, duty_c, sector, input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, sector, output ready);
endinterface

// ===== design/inverse_park_clarke_svpwm.sv =====
// Space vector PWM with inverse Park and inverse Clarke transforms.
// Input channel in_ch: rotor angle (fraction of a turn) and d/q voltage
// commands in Q1.15. Output channel out_ch: three phase compare values in
// timer counts, each clamped to 0..period, and the sector number 1..6.
// Both channels use valid/ready; a request moves when both are high.
// cfg_we/cfg_data write the PWM period; write it only while the block holds
// no request in flight.
// The pipeline stages from input to output are: sine/cosine ROM read, four
// products, alpha/beta sums, reference scaling, sector select, period
// products, doubled duty sums, clamp and phase routing into the output
// register. One request per cycle is sustained while out_ch.ready is high.
// Each stage holds its request while the next is full, so bubbles close up
// while the receiver stalls; in_ch.ready falls only when all eight stages
// are full. Ready is combinational from out_ch.ready through the stages.
// Reset empties the pipeline and sets the period to 4000 counts.
module inverse_park_clarke_svpwm
  import ipcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ipcs_in_if.sink     in_ch,
  ipcs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic [15:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_data;
    end
  end

  logic  sc_valid, sc_ready;
  sc_t   sc_data;
  logic  ab_valid, ab_ready;
  ab_t   ab_data;
  logic  sd_valid, sd_ready;
  sect_t sd_data;
  res_t  res_data;

  ipcs_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .angle     (in_ch.angle),
    .vd        (in_ch.vd),
    .vq        (in_ch.vq),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc_data)
  );

  ipcs_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_data   (sc_data),
    .out_valid (ab_valid),
    .out_ready (ab_ready),
    .out_data  (ab_data)
  );

  ipcs_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ab_valid),
    .in_ready  (ab_ready),
    .in_data   (ab_data),
    .out_valid (sd_valid),
    .out_ready (sd_ready),
    .out_data  (sd_data)
  );

  ipcs_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .period    (period_r),
    .in_valid  (sd_valid),
    .in_ready  (sd_ready),
    .in_data   (sd_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res_data)
  );

  assign out_ch.duty_a = res_data.duty_a;
  assign out_ch.duty_b = res_data.duty_b;
  assign out_ch.duty_c = res_data.duty_c;
  assign out_ch.sector = res_data.sector;

`ifndef NO_ASSERTIONS
  a_duty_le_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.duty_a <= period_r) && (out_ch.duty_b <= period_r) &&
                     (out_ch.duty_c <= period_r))
    else $error("duty above period");

  a_sec3_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.sector == SEC_3)) |->
      (out_ch.duty_a >= out_ch.duty_b) && (out_ch.duty_b >= out_ch.duty_c))
    else $error("sector 3 duty order");

  a_sec4_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.sector == SEC_4)) |->
      (out_ch.duty_c >= out_ch.duty_b) && (out_ch.duty_b >= out_ch.duty_a))
    else $error("sector 4 duty order");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== design/ipcs_sincos.sv =====
module ipcs_sincos
  import ipcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        angle,
  input  logic signed [15:0] vd,
  input  logic signed [15:0] vq,
  output logic               out_valid,
  input  logic               out_ready,
  output sc_t                out_data
);

  logic [15:0] rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(k);
  end

  logic [15:0]          cos_ang;
  logic [SIN_IDX_W-1:0] s_addr;
  logic [SIN_IDX_W-1:0] c_addr;
  logic signed [16:0]   s_mag;
  logic signed [16:0]   c_mag;
  logic                 v_r;
  sc_t                  d_r;
  sc_t                  d_nxt;

  assign cos_ang = angle + 16'd16384;
  assign s_addr  = sine_addr(angle);
  assign c_addr  = sine_addr(cos_ang);
  assign s_mag   = $signed({1'b0, rom[s_addr]});
  assign c_mag   = $signed({1'b0, rom[c_addr]});

  always_comb begin
    d_nxt.s  = angle[15] ? -s_mag : s_mag;
    d_nxt.c  = cos_ang[15] ? -c_mag : c_mag;
    d_nxt.vd = vd;
    d_nxt.vq = vq;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ===== design/ipcs_rotate.sv =====
module ipcs_rotate
  import ipcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sc_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output ab_t  out_data
);

  logic                     v1_r;
  logic                     v2_r;
  logic                     rdy1;
  logic                     rdy2;
  logic signed [PROD_W-1:0] vdc_r, vds_r, vqc_r, vqs_r;
  logic signed [PROD_W-1:0] vdc_nxt, vds_nxt, vqc_nxt, vqs_nxt;
  ab_t                      ab_r;
  ab_t                      ab_nxt;

  assign vdc_nxt = PROD_W'(in_data.vd) * PROD_W'(in_data.c);
  assign vds_nxt = PROD_W'(in_data.vd) * PROD_W'(in_data.s);
  assign vqc_nxt = PROD_W'(in_data.vq) * PROD_W'(in_data.c);
  assign vqs_nxt = PROD_W'(in_data.vq) * PROD_W'(in_data.s);

  always_comb begin
    ab_nxt.alpha = AB_W'(vdc_r) - AB_W'(vqs_r);
    ab_nxt.beta  = AB_W'(vds_r) + AB_W'(vqc_r);
  end

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      vdc_r <= vdc_nxt;
      vds_r <= vds_nxt;
      vqc_r <= vqc_nxt;
      vqs_r <= vqs_nxt;
    end
    if (rdy2 && v1_r) begin
      ab_r <= ab_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = ab_r;

endmodule

// ===== design/ipcs_sector.sv =====
module ipcs_sector
  import ipcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  ab_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output sect_t out_data
);

  logic                  v1_r;
  logic                  v2_r;
  logic                  rdy1;
  logic                  rdy2;
  logic signed [R_W-1:0] r1_r, r2_r, r3_r;
  logic signed [R_W-1:0] r1_nxt, r2_nxt, r3_nxt;
  logic signed [R_W-1:0] alpha_k;
  logic signed [R_W-1:0] beta_h;
  logic signed [R_W-1:0] t1r;
  logic signed [R_W-1:0] t2r;
  sect_t                 sd_r;
  sect_t                 sd_nxt;

  assign alpha_k = R_W'(in_data.alpha) * R_W'(SQRT3_X2);
  assign beta_h  = R_W'(in_data.beta) <<< 16;
  assign r1_nxt  = R_W'(in_data.beta) <<< 17;
  assign r2_nxt  = alpha_k - beta_h;
  assign r3_nxt  = -alpha_k - beta_h;

  // a reference of zero counts as positive
  always_comb begin
    if (!r1_r[R_W-1]) begin
      if (!r2_r[R_W-1]) begin
        sd_nxt.sector = SEC_3;
        t1r           = r2_r;
        t2r           = r1_r;
      end else if (!r3_r[R_W-1]) begin
        sd_nxt.sector = SEC_5;
        t1r           = r1_r;
        t2r           = r3_r;
      end else begin
        sd_nxt.sector = SEC_1;
        t1r           = -r2_r;
        t2r           = -r3_r;
      end
    end else begin
      if (!r2_r[R_W-1]) begin
        if (!r3_r[R_W-1]) begin
          sd_nxt.sector = SEC_6;
          t1r           = r3_r;
          t2r           = r2_r;
        end else begin
          sd_nxt.sector = SEC_2;
          t1r           = -r3_r;
          t2r           = -r1_r;
        end
      end else begin
        sd_nxt.sector = SEC_4;
        t1r           = -r1_r;
        t2r           = -r2_r;
      end
    end
    sd_nxt.t1 = t1r[R_W-2:15];
    sd_nxt.t2 = t2r[R_W-2:15];
  end

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
    end
    if (rdy2 && v1_r) begin
      sd_r <= sd_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = sd_r;

endmodule

// ===== design/ipcs_duty.sv =====
module ipcs_duty
  import ipcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] period,
  input  logic        in_valid,
  output logic        in_ready,
  input  sect_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);

  function automatic logic [15:0] clamp_duty(input logic signed [D_W-1:0] d,
                                             input logic [15:0] p);
    logic [D_W-34:0] c;
    c = d[D_W-1:33];
    if (d[D_W-1]) begin
      return 16'd0;
    end
    return (c > (D_W-33)'(p)) ? p : c[15:0];
  endfunction

  logic                  v1_r, v2_r, v3_r;
  logic                  rdy1, rdy2, rdy3;
  logic [M_W-1:0]        m1_r, m2_r;
  logic [M_W-1:0]        m1_nxt, m2_nxt;
  sector_t               sec1_r, sec2_r;
  logic signed [D_W-1:0] pq;
  logic signed [D_W-1:0] m1_s, m2_s;
  logic signed [D_W-1:0] ta2_r, tb2_r, tc2_r;
  logic signed [D_W-1:0] ta2_nxt, tb2_nxt, tc2_nxt;
  logic [15:0]           ta, tb, tcv;
  res_t                  res_r;
  res_t                  res_nxt;

  assign m1_nxt = M_W'(period) * M_W'(in_data.t1);
  assign m2_nxt = M_W'(period) * M_W'(in_data.t2);

  assign pq      = $signed(D_W'({period, 32'd0}));
  assign m1_s    = $signed(D_W'(m1_r));
  assign m2_s    = $signed(D_W'(m2_r));
  assign tc2_nxt = pq - m1_s - m2_s;
  assign tb2_nxt = pq + m1_s - m2_s;
  assign ta2_nxt = pq + m1_s + m2_s;

  assign ta  = clamp_duty(ta2_r, period);
  assign tb  = clamp_duty(tb2_r, period);
  assign tcv = clamp_duty(tc2_r, period);

  always_comb begin
    res_nxt.sector = sec2_r;
    case (sec2_r)
      SEC_3: begin
        res_nxt.duty_a = ta;
        res_nxt.duty_b = tb;
        res_nxt.duty_c = tcv;
      end
      SEC_5: begin
        res_nxt.duty_a = tcv;
        res_nxt.duty_b = ta;
        res_nxt.duty_c = tb;
      end
      SEC_1: begin
        res_nxt.duty_a = tb;
        res_nxt.duty_b = ta;
        res_nxt.duty_c = tcv;
      end
      SEC_6: begin
        res_nxt.duty_a = tb;
        res_nxt.duty_b = tcv;
        res_nxt.duty_c = ta;
      end
      SEC_2: begin
        res_nxt.duty_a = ta;
        res_nxt.duty_b = tcv;
        res_nxt.duty_c = tb;
      end
      default: begin
        res_nxt.duty_a = tcv;
        res_nxt.duty_b = tb;
        res_nxt.duty_c = ta;
      end
    endcase
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      sec1_r <= in_data.sector;
    end
    if (rdy2 && v1_r) begin
      ta2_r  <= ta2_nxt;
      tb2_r  <= tb2_nxt;
      tc2_r  <= tc2_nxt;
      sec2_r <= sec1_r;
    end
    if (rdy3 && v2_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = res_r;

endmodule
